>>> hw/rtl/rlbig_pkg.sv
// Shared types and constants for the ragged list broadcast index generator.
// Holds the item structs, the check result codes and the subtract unit types.
// No dependencies.
package rlbig_pkg;

	localparam int DATA_W            = 32;
	localparam int MAX_LIST_LEN_DEF  = 64;
	localparam int INDEX_BITS_DEF    = 32;

	// Check result codes carried with each result item.
	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_STOP = 3'd1,
		ERR_DECR = 3'd2,
		ERR_LEN  = 3'd3,
		ERR_LONG = 3'd4,
		ERR_HALT = 3'd5
	} err_code_t;

	// Operand selection for the shared subtract unit.
	typedef enum logic [1:0] {
		OP_LEN  = 2'd0,
		OP_OFF  = 2'd1,
		OP_CLEN = 2'd2
	} sub_op_t;

	// Registered subtract result: borrow set when the minuend is the smaller.
	typedef struct packed {
		logic              borrow;
		logic [DATA_W-1:0] diff;
	} sub_res_t;

	typedef struct packed {
		logic              first_list;
		logic [DATA_W-1:0] list_start;
		logic [DATA_W-1:0] list_stop;
		logic [DATA_W-1:0] offset_begin;
		logic [DATA_W-1:0] offset_end;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] carry_index;
		logic [DATA_W-1:0] out_position;
		logic              element_valid;
		logic              last;
		err_code_t         error_code;
		logic [DATA_W-1:0] error_list;
	} out_item_t;

endpackage

>>> hw/rtl/rlbig_sub_unit.sv
// Shared 32-bit subtract unit with operand selection and a result register.
// Used in turn for the list length, the offset difference and the content bound.
// Depends on rlbig_pkg.
module rlbig_sub_unit (
	input  logic                    clk,
	input  rlbig_pkg::sub_op_t      op,
	input  rlbig_pkg::in_item_t     item,
	input  logic [rlbig_pkg::DATA_W-1:0] content_length,
	output rlbig_pkg::sub_res_t     res
);

	logic [rlbig_pkg::DATA_W-1:0] opa;
	logic [rlbig_pkg::DATA_W-1:0] opb;
	logic [rlbig_pkg::DATA_W:0]   wide;

	// Operand selection for the three checks.
	always_comb begin
		unique case (op)
			rlbig_pkg::OP_LEN: begin
				opa = item.list_stop;
				opb = item.list_start;
			end
			rlbig_pkg::OP_OFF: begin
				opa = item.offset_end;
				opb = item.offset_begin;
			end
			rlbig_pkg::OP_CLEN: begin
				opa = content_length;
				opb = item.list_stop;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// One extra bit catches the borrow.
	assign wide = {1'b0, opa} - {1'b0, opb};

	// Result register.
	always_ff @(posedge clk) begin
		res.borrow <= wide[rlbig_pkg::DATA_W];
		res.diff   <= wide[rlbig_pkg::DATA_W-1:0];
	end

endmodule

>>> hw/rtl/ragged_list_broadcast_index_gen.sv
// Top level of the ragged list broadcast index generator.
// Sequencer, state counters and output register; uses rlbig_sub_unit and rlbig_pkg.
//
// Usage: each input item on in_data describes one list (start, stop and the
// target offset pair). The item is accepted when in_valid is high and in_stall
// is low. The block checks the list with three subtractions on one shared
// subtractor, then emits one result item per element on out_data (valid/stall),
// each with its content index, running output position and a last flag.
// An empty list, an error or a halted block gives a single marker item.
// The first result is registered in the marker or element state, after the length,
// offset, content bound and check states. The emit phase is set by the single output
// register, one element per cycle while the receiver does not stall. in_stall is high
// from acceptance until the last result is loaded. When the receiver stalls, the
// output register holds its item and the sequencer waits. The user must write
// content_length by cfg_we with cfg_data only while idle; the block itself does not
// enforce it. Reset clears the output count, list number, failed list, halt flag,
// content_length and the output valid flag; no clearing pass is needed.
module ragged_list_broadcast_index_gen #(
	parameter int MAX_LIST_LEN = rlbig_pkg::MAX_LIST_LEN_DEF,
	parameter int INDEX_BITS   = rlbig_pkg::INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rlbig_pkg::DATA_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rlbig_pkg::in_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rlbig_pkg::out_item_t          out_data
);

	localparam int DW     = rlbig_pkg::DATA_W;
	localparam int CNT_W  = $clog2(MAX_LIST_LEN + 1);
	localparam int MASK_W = (INDEX_BITS < DW) ? INDEX_BITS : DW;
	localparam logic [DW-1:0] IDX_MASK = {DW{1'b1}} >> (DW - MASK_W);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LEN   = 7'b0000010,
		ST_OFF   = 7'b0000100,
		ST_CLEN  = 7'b0001000,
		ST_CHECK = 7'b0010000,
		ST_MARK  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic                   out_valid_q;
	rlbig_pkg::out_item_t   out_q;
	logic [DW-1:0]          content_length_q;
	logic [DW-1:0]          output_count_q;
	logic [DW-1:0]          list_number_q;
	logic                   halted_q;
	logic [DW-1:0]          failed_list_q;

	rlbig_pkg::in_item_t    item_q;
	rlbig_pkg::sub_res_t    len_q;
	rlbig_pkg::sub_res_t    off_q;
	rlbig_pkg::err_code_t   code_q;
	logic [DW-1:0]          idx_q;
	logic [DW-1:0]          pos_q;
	logic [CNT_W-1:0]       rem_q;

	rlbig_pkg::sub_op_t     op;
	rlbig_pkg::sub_res_t    res;
	rlbig_pkg::err_code_t   code_c;
	logic                   slot_free;
	logic                   accept;
	logic                   emit_last;

	// Shared subtractor.
	rlbig_sub_unit u_sub (
		.clk            (clk),
		.op             (op),
		.item           (item_q),
		.content_length (content_length_q),
		.res            (res)
	);

	always_comb begin
		unique case (state_q)
			ST_LEN:  op = rlbig_pkg::OP_LEN;
			ST_OFF:  op = rlbig_pkg::OP_OFF;
			default: op = rlbig_pkg::OP_CLEN;
		endcase
	end

	// Check decision, in priority order; res holds content_length - stop here.
	always_comb begin
		if (halted_q) begin
			code_c = rlbig_pkg::ERR_HALT;
		end else if ((len_q.diff != '0) && res.borrow) begin
			code_c = rlbig_pkg::ERR_STOP;
		end else if (off_q.borrow) begin
			code_c = rlbig_pkg::ERR_DECR;
		end else if (len_q.borrow || (len_q.diff != off_q.diff)) begin
			code_c = rlbig_pkg::ERR_LEN;
		end else if (len_q.diff > DW'(MAX_LIST_LEN)) begin
			code_c = rlbig_pkg::ERR_LONG;
		end else begin
			code_c = rlbig_pkg::ERR_NONE;
		end
	end

	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign slot_free = !out_valid_q || !out_stall;
	assign emit_last = (rem_q == CNT_W'(1));
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Control state: sequencer, counters, halt flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			out_valid_q      <= 1'b0;
			content_length_q <= '0;
			output_count_q   <= '0;
			list_number_q    <= '0;
			halted_q         <= 1'b0;
			failed_list_q    <= '0;
		end else begin
			if (cfg_we) begin
				content_length_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.first_list) begin
							output_count_q <= '0;
							list_number_q  <= '0;
							halted_q       <= 1'b0;
							failed_list_q  <= '0;
						end
						state_q <= ST_LEN;
					end
				end
				ST_LEN:  state_q <= ST_OFF;
				ST_OFF:  state_q <= ST_CLEN;
				ST_CLEN: state_q <= ST_CHECK;
				ST_CHECK: begin
					if ((code_c != rlbig_pkg::ERR_NONE) || (len_q.diff == '0)) begin
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_MARK: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (code_q == rlbig_pkg::ERR_NONE) begin
							list_number_q <= list_number_q + 1'b1;
						end else if (code_q != rlbig_pkg::ERR_HALT) begin
							halted_q      <= 1'b1;
							failed_list_q <= list_number_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (emit_last) begin
							output_count_q <= pos_q + 1'b1;
							list_number_q  <= list_number_q + 1'b1;
							state_q        <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: item copy, check results, element walk, result item.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == ST_OFF) begin
			len_q <= res;
		end
		if (state_q == ST_CLEN) begin
			off_q <= res;
		end
		if (state_q == ST_CHECK) begin
			code_q <= code_c;
			idx_q  <= item_q.list_start;
			pos_q  <= output_count_q;
			rem_q  <= len_q.diff[CNT_W-1:0];
		end
		if ((state_q == ST_MARK) && slot_free) begin
			out_q.carry_index   <= '0;
			out_q.out_position  <= output_count_q;
			out_q.element_valid <= 1'b0;
			out_q.last          <= 1'b1;
			out_q.error_code    <= code_q;
			if (code_q == rlbig_pkg::ERR_HALT) begin
				out_q.error_list <= failed_list_q;
			end else if (code_q == rlbig_pkg::ERR_NONE) begin
				out_q.error_list <= '0;
			end else begin
				out_q.error_list <= list_number_q;
			end
		end
		if ((state_q == ST_EMIT) && slot_free) begin
			out_q.carry_index   <= idx_q & IDX_MASK;
			out_q.out_position  <= pos_q;
			out_q.element_valid <= 1'b1;
			out_q.last          <= emit_last;
			out_q.error_code    <= rlbig_pkg::ERR_NONE;
			out_q.error_list    <= '0;
			idx_q               <= idx_q + 1'b1;
			pos_q               <= pos_q + 1'b1;
			rem_q               <= rem_q - 1'b1;
		end
	end

`ifndef SYNTH
	// A result item appears only from the marker or element states.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_MARK || $past(state_q) == ST_EMIT))
		else $error("result item loaded outside the marker and element states");

	// A marker item always closes its input item.
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.element_valid) |-> out_q.last)
		else $error("marker item without last flag");

	// An element never carries an error code.
	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.element_valid) |-> (out_q.error_code == rlbig_pkg::ERR_NONE))
		else $error("element item carries an error code");

	// The halt flag is set only when an error marker is loaded.
	a_halt_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> ($past(state_q) == ST_MARK))
		else $error("halt flag set outside the marker state");

	// The element walk never runs with no elements left.
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q != '0))
		else $error("element state with zero remaining count");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the ragged list broadcast index generator.
// Sends list items and content_length writes, predicts every result item and checks each field.
// Depends on rlbig_pkg and the ragged_list_broadcast_index_gen top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN     = rlbig_pkg::MAX_LIST_LEN_DEF;
	localparam int HOLD_SPAN   = 400;
	localparam int PHASE_ITEMS = 83;
	localparam logic [31:0] IDX_MASK =
		(rlbig_pkg::INDEX_BITS_DEF >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << rlbig_pkg::INDEX_BITS_DEF) - 32'd1);

	typedef enum {ROW_LIST, ROW_MARK, ROW_CFG} row_kind_t;

	// One line of the directed table: a list item, a list item with a typed
	// marker result, or a content_length write.
	typedef struct {
		row_kind_t            kind;
		rlbig_pkg::in_item_t  item;
		logic [31:0]          cfg_value;
		rlbig_pkg::err_code_t code;
		logic [31:0]          position;
		logic [31:0]          err_list;
	} dir_row_t;

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [rlbig_pkg::DATA_W-1:0] cfg_data  = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	rlbig_pkg::in_item_t          in_data   = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	rlbig_pkg::out_item_t         out_data;

	// Predicted state of the block.
	logic [31:0] content_len = '0;
	logic [31:0] pos_count   = '0;
	logic [31:0] lists_seen  = '0;
	logic        halt_flag   = 1'b0;
	logic [31:0] halt_list   = '0;

	rlbig_pkg::out_item_t expected_elements[$];
	dir_row_t             dir_rows[$];

	int tx_pct      = 0;
	int rx_pct      = 0;
	int hold_req    = 0;
	int hold_ack    = 0;
	int hold_left   = 0;
	int mismatches  = 0;
	int results_seen = 0;
	int items_sent  = 0;
	int dir_items   = 0;
	int empty_marks = 0;
	int error_marks = 0;
	int halt_marks  = 0;

	ragged_list_broadcast_index_gen #(
		.MAX_LIST_LEN(MAX_LEN),
		.INDEX_BITS  (rlbig_pkg::INDEX_BITS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the run, well beyond the slowest correct run.
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// Works out the result items of one list item and advances the predicted state.
	function automatic void predict_list(input rlbig_pkg::in_item_t it,
			ref rlbig_pkg::out_item_t res[$]);
		rlbig_pkg::out_item_t r;
		rlbig_pkg::err_code_t code;
		logic [31:0]          span;
		span = it.list_stop - it.list_start;
		if (it.first_list) begin
			pos_count  = '0;
			lists_seen = '0;
			halt_flag  = 1'b0;
			halt_list  = '0;
		end
		r = '0;
		r.last = 1'b1;
		r.out_position = pos_count;
		r.error_code = rlbig_pkg::ERR_NONE;
		if (halt_flag) begin
			r.error_code = rlbig_pkg::ERR_HALT;
			r.error_list = halt_list;
			res.push_back(r);
			return;
		end
		// The checks are taken in a fixed order; the first that fails wins.
		code = rlbig_pkg::ERR_NONE;
		if (it.list_start != it.list_stop && it.list_stop > content_len)
			code = rlbig_pkg::ERR_STOP;
		else if (it.offset_end < it.offset_begin)
			code = rlbig_pkg::ERR_DECR;
		else if (it.list_stop < it.list_start || span != it.offset_end - it.offset_begin)
			code = rlbig_pkg::ERR_LEN;
		else if (span > MAX_LEN)
			code = rlbig_pkg::ERR_LONG;
		if (code != rlbig_pkg::ERR_NONE) begin
			halt_flag = 1'b1;
			halt_list = lists_seen;
			r.error_code = code;
			r.error_list = lists_seen;
			res.push_back(r);
			return;
		end
		lists_seen = lists_seen + 32'd1;
		if (span == 0) begin
			res.push_back(r);
			return;
		end
		for (int unsigned j = 0; j < span; j++) begin
			r.carry_index   = (it.list_start + j) & IDX_MASK;
			r.out_position  = pos_count + j;
			r.element_valid = 1'b1;
			r.last          = (j + 1 == span);
			res.push_back(r);
		end
		pos_count = pos_count + span;
	endfunction

	// Mostly well-formed lists that fit the content, with some broken ones.
	function automatic rlbig_pkg::in_item_t make_list_item();
		rlbig_pkg::in_item_t it;
		logic [31:0]         len;
		logic [31:0]         room;
		logic [31:0]         tmp;
		int                  pick;
		pick = $urandom_range(99);
		it.first_list = halt_flag ? ($urandom_range(99) < 80) : ($urandom_range(99) < 4);
		if (pick < 65)
			len = $urandom_range(6, 0);
		else if (pick < 90)
			len = $urandom_range(MAX_LEN, 7);
		else
			len = $urandom_range(MAX_LEN + 1, MAX_LEN - 1);
		if (len > content_len)
			len = content_len;
		room = content_len - len;
		it.list_start = $urandom;
		if (it.list_start > room)
			it.list_start = it.list_start % (room + 32'd1);
		it.list_stop    = it.list_start + len;
		it.offset_begin = $urandom;
		it.offset_end   = it.offset_begin + len;
		if ($urandom_range(99) < 10) begin
			case ($urandom_range(3))
				0: begin
					it.list_stop = $urandom;
				end
				1: begin
					it.offset_end = $urandom;
				end
				2: begin
					tmp = it.list_start;
					it.list_start = it.list_stop;
					it.list_stop = tmp;
				end
				default: begin
					it.list_stop = content_len + $urandom_range(4, 1);
				end
			endcase
		end
		return it;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] check failed: %s", $time, what);
	endtask

	// Compares one accepted result item with the oldest expectation.
	task automatic check_result(input rlbig_pkg::out_item_t got);
		rlbig_pkg::out_item_t want;
		if (expected_elements.size() == 0) begin
			report_mismatch($sformatf(
				"result item with nothing expected, carry_index %h position %h",
				got.carry_index, got.out_position));
			return;
		end
		want = expected_elements.pop_front();
		results_seen++;
		if (!want.element_valid) begin
			case (want.error_code)
				rlbig_pkg::ERR_NONE: empty_marks++;
				rlbig_pkg::ERR_HALT: halt_marks++;
				default:             error_marks++;
			endcase
		end
		if (got.carry_index !== want.carry_index)
			report_mismatch($sformatf("carry_index %h, expected %h",
				got.carry_index, want.carry_index));
		if (got.out_position !== want.out_position)
			report_mismatch($sformatf("out_position %h, expected %h",
				got.out_position, want.out_position));
		if (got.element_valid !== want.element_valid)
			report_mismatch($sformatf("element_valid %b, expected %b",
				got.element_valid, want.element_valid));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
		if (got.error_code !== want.error_code)
			report_mismatch($sformatf("error_code %0d, expected %0d",
				got.error_code, want.error_code));
		if (got.error_list !== want.error_list)
			report_mismatch($sformatf("error_list %h, expected %h",
				got.error_list, want.error_list));
	endtask

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_SPAN;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result(out_data);
	end

	// Waits until every expected result has come, then lets the block settle.
	task automatic wait_idle();
		while (expected_elements.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_content_len(input logic [31:0] value);
		in_valid <= 1'b0;
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		content_len = value;
	endtask

	// Offers one list item, waits for it to be taken and records its results.
	// A typed marker replaces the predicted results where the table gives one.
	task automatic offer_item(input rlbig_pkg::in_item_t it, input bit typed,
			input rlbig_pkg::out_item_t mark);
		rlbig_pkg::out_item_t predicted[$];
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		predict_list(it, predicted);
		if (typed)
			expected_elements.push_back(mark);
		else
			foreach (predicted[k])
				expected_elements.push_back(predicted[k]);
		items_sent++;
	endtask

	function automatic void add_row(input row_kind_t kind, input logic fl,
			input logic [31:0] start, input logic [31:0] stop,
			input logic [31:0] ob, input logic [31:0] oe,
			input rlbig_pkg::err_code_t code, input logic [31:0] pos,
			input logic [31:0] el);
		dir_row_t row;
		row.kind              = kind;
		row.item.first_list   = fl;
		row.item.list_start   = start;
		row.item.list_stop    = stop;
		row.item.offset_begin = ob;
		row.item.offset_end   = oe;
		row.cfg_value         = '0;
		row.code              = code;
		row.position          = pos;
		row.err_list          = el;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg_row(input logic [31:0] value);
		dir_row_t row;
		row.kind      = ROW_CFG;
		row.item      = '0;
		row.cfg_value = value;
		row.code      = rlbig_pkg::ERR_NONE;
		row.position  = '0;
		row.err_list  = '0;
		dir_rows.push_back(row);
	endfunction

	initial begin
		dir_row_t             row;
		rlbig_pkg::out_item_t mark;
		tx_pct = 13;
		rx_pct <= 72;

		// Empty content: an empty list passes, any other list fails, then halt.
		add_cfg_row(32'd0);
		add_row(ROW_MARK, 1'b0, 32'd5, 32'd5, 32'd7, 32'd7,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_MARK, 1'b0, 32'd0, 32'd1, 32'd0, 32'd1,
			rlbig_pkg::ERR_STOP, 32'd0, 32'd1);
		add_row(ROW_MARK, 1'b0, 32'd2, 32'd2, 32'd0, 32'd0,
			rlbig_pkg::ERR_HALT, 32'd0, 32'd1);
		// Full content range: lists at the top of the index space, the longest
		// list, one too long, and the offset order and length checks failing after a new first list.
		add_cfg_row(32'hFFFF_FFFF);
		add_row(ROW_LIST, 1'b1, 32'hFFFF_FFC0, 32'hFFFF_FFFF, 32'd0, 32'd63,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_LIST, 1'b0, 32'hFFFF_FFBF, 32'hFFFF_FFFF, 32'hFFFF_FFBF, 32'hFFFF_FFFF,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_MARK, 1'b0, 32'd10, 32'd75, 32'd0, 32'd65,
			rlbig_pkg::ERR_LONG, 32'd127, 32'd2);
		add_row(ROW_MARK, 1'b1, 32'd3, 32'd4, 32'd9, 32'd8,
			rlbig_pkg::ERR_DECR, 32'd0, 32'd0);
		add_row(ROW_MARK, 1'b1, 32'd9, 32'd4, 32'd0, 32'd0,
			rlbig_pkg::ERR_LEN, 32'd0, 32'd0);
		add_row(ROW_MARK, 1'b1, 32'd0, 32'd4, 32'd0, 32'd5,
			rlbig_pkg::ERR_LEN, 32'd0, 32'd0);
		add_row(ROW_MARK, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_MARK, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_LIST, 1'b0, 32'd0, 32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		// Small content: stop at the limit, empty lists beyond it, and a stop
		// below start whose wrapped length would otherwise match the offsets.
		add_cfg_row(32'd40);
		add_row(ROW_MARK, 1'b0, 32'd30, 32'd41, 32'd0, 32'd11,
			rlbig_pkg::ERR_STOP, 32'd1, 32'd3);
		add_row(ROW_MARK, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0,
			rlbig_pkg::ERR_HALT, 32'd1, 32'd3);
		add_row(ROW_LIST, 1'b1, 32'd30, 32'd40, 32'd100, 32'd110,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_LIST, 1'b0, 32'd40, 32'd40, 32'd5, 32'd5,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_LIST, 1'b0, 32'd50, 32'd50, 32'd1, 32'd1,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);
		add_row(ROW_MARK, 1'b0, 32'd0, 32'd1, 32'd3, 32'd2,
			rlbig_pkg::ERR_DECR, 32'd10, 32'd3);
		add_row(ROW_MARK, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0,
			rlbig_pkg::ERR_HALT, 32'd10, 32'd3);
		add_row(ROW_MARK, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1,
			rlbig_pkg::ERR_LEN, 32'd0, 32'd0);
		add_row(ROW_LIST, 1'b1, 32'd0, 32'd40, 32'd0, 32'd40,
			rlbig_pkg::ERR_NONE, 32'd0, 32'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				write_content_len(row.cfg_value);
			end else begin
				mark = '0;
				mark.last         = 1'b1;
				mark.out_position = row.position;
				mark.error_code   = row.code;
				mark.error_list   = row.err_list;
				offer_item(row.item, row.kind == ROW_MARK, mark);
				dir_items++;
			end
		end

		// Random part in three phases of idling, each with its own content length.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_pct = 13;
					rx_pct <= 72;
					write_content_len(32'hFFFF_FFFF);
				end
				1: begin
					tx_pct = 72;
					rx_pct <= 13;
					write_content_len($urandom_range(4000, 100));
				end
				default: begin
					tx_pct = 0;
					rx_pct <= 0;
					write_content_len(32'h8000_0000 | $urandom);
					// Long receiver hold-off while items keep coming.
					hold_req <= hold_req + 1;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_item(make_list_item(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		wait_idle();
		repeat (12) @(posedge clk);
		if (expected_elements.size() != 0)
			report_mismatch($sformatf("%0d expected result items never arrived",
				expected_elements.size()));

		$display("Run covered %0d list items (%0d directed) under three idle patterns",
			items_sent, dir_items);
		$display("and a long receiver hold-off; %0d result items checked,", results_seen);
		$display("%0d empty, %0d errors, %0d halted.", empty_marks, error_marks, halt_marks);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/rlbig_pkg.sv
hw/rtl/rlbig_sub_unit.sv
hw/rtl/ragged_list_broadcast_index_gen.sv
sim/tb_top.sv
